### rtl/rpn_pkg.sv
// Shared types, character codes, error codes and the microcode ROM of the RPN calculator.
package rpn_pkg;

  localparam int UPC_W = 5;

  // Character codes
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_CARET = 8'h5E;

  // Factorial wraps to zero from this argument on
  localparam logic [31:0] FACT_ZERO_FROM = 32'd34;
  localparam logic [5:0]  DIV_STEPS      = 6'd32;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_UNDER = 2'd1,
    ERR_OVER  = 2'd2,
    ERR_DIV0  = 2'd3
  } err_e;

  typedef enum logic [2:0] {
    K_DIGIT, K_ADD, K_SUB, K_MUL, K_DIV, K_POW, K_FACT, K_OTHER
  } kind_e;

  typedef enum logic [3:0] {
    U_NOP, U_FETCH, U_DECODE, U_LD_B, U_LD_A, U_ALU, U_DIV_INIT, U_DIV_STEP,
    U_DIV_FIX, U_POW_INIT, U_POW_MUL, U_POW_SQ, U_FACT_INIT, U_FACT_STEP,
    U_WB, U_FINISH
  } uop_e;

  typedef enum logic [3:0] {
    C_NEVER, C_ALWAYS, C_NO_ACC, C_SIMPLE, C_IS_FACT, C_IS_DIV, C_IS_POW,
    C_DIVZ, C_CNT_NZ, C_EXP_LE0, C_E_NZ, C_FACT_TRIV, C_I_LT_N, C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    uop_e             uop;
    cond_e            cond;
    logic [UPC_W-1:0] target;
    logic             ret;     // no jump: back to fetch instead of next step
  } ucode_t;

  // Step addresses
  localparam logic [UPC_W-1:0] S_FETCH     = 5'd0;
  localparam logic [UPC_W-1:0] S_DECODE    = 5'd1;
  localparam logic [UPC_W-1:0] S_LD_B      = 5'd2;
  localparam logic [UPC_W-1:0] S_LD_A      = 5'd3;
  localparam logic [UPC_W-1:0] S_DISP      = 5'd4;
  localparam logic [UPC_W-1:0] S_ALU       = 5'd5;
  localparam logic [UPC_W-1:0] S_DIV_INIT  = 5'd6;
  localparam logic [UPC_W-1:0] S_DIV_STEP  = 5'd7;
  localparam logic [UPC_W-1:0] S_DIV_FIX   = 5'd8;
  localparam logic [UPC_W-1:0] S_POW_INIT  = 5'd9;
  localparam logic [UPC_W-1:0] S_POW_MUL   = 5'd10;
  localparam logic [UPC_W-1:0] S_POW_SQ    = 5'd11;
  localparam logic [UPC_W-1:0] S_POW_END   = 5'd12;
  localparam logic [UPC_W-1:0] S_FACT_INIT = 5'd13;
  localparam logic [UPC_W-1:0] S_FACT_STEP = 5'd14;
  localparam logic [UPC_W-1:0] S_WB        = 5'd15;
  localparam logic [UPC_W-1:0] S_FINISH    = 5'd16;

  function automatic kind_e classify(input logic [7:0] c);
    kind_e k;
    k = K_OTHER;
    if (c >= CH_0 && c <= CH_9) k = K_DIGIT;
    else if (c == CH_PLUS)      k = K_ADD;
    else if (c == CH_MINUS)     k = K_SUB;
    else if (c == CH_STAR)      k = K_MUL;
    else if (c == CH_SLASH)     k = K_DIV;
    else if (c == CH_CARET)     k = K_POW;
    else if (c == CH_BANG)      k = K_FACT;
    return k;
  endfunction

  // Control store
  function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] addr);
    ucode_t w;
    w = '{uop: U_NOP, cond: C_NEVER, target: S_FETCH, ret: 1'b1};
    unique case (addr)
      S_FETCH:     w = '{U_FETCH,     C_NO_ACC,    S_FETCH,     1'b0};
      S_DECODE:    w = '{U_DECODE,    C_SIMPLE,    S_FINISH,    1'b0};
      S_LD_B:      w = '{U_LD_B,      C_IS_FACT,   S_FACT_INIT, 1'b0};
      S_LD_A:      w = '{U_LD_A,      C_IS_DIV,    S_DIV_INIT,  1'b0};
      S_DISP:      w = '{U_NOP,       C_IS_POW,    S_POW_INIT,  1'b0};
      S_ALU:       w = '{U_ALU,       C_ALWAYS,    S_WB,        1'b0};
      S_DIV_INIT:  w = '{U_DIV_INIT,  C_DIVZ,      S_FINISH,    1'b0};
      S_DIV_STEP:  w = '{U_DIV_STEP,  C_CNT_NZ,    S_DIV_STEP,  1'b0};
      S_DIV_FIX:   w = '{U_DIV_FIX,   C_ALWAYS,    S_WB,        1'b0};
      S_POW_INIT:  w = '{U_POW_INIT,  C_EXP_LE0,   S_WB,        1'b0};
      S_POW_MUL:   w = '{U_POW_MUL,   C_NEVER,     S_FETCH,     1'b0};
      S_POW_SQ:    w = '{U_POW_SQ,    C_E_NZ,      S_POW_MUL,   1'b0};
      S_POW_END:   w = '{U_NOP,       C_ALWAYS,    S_WB,        1'b0};
      S_FACT_INIT: w = '{U_FACT_INIT, C_FACT_TRIV, S_WB,        1'b0};
      S_FACT_STEP: w = '{U_FACT_STEP, C_I_LT_N,    S_FACT_STEP, 1'b0};
      S_WB:        w = '{U_WB,        C_NEVER,     S_FETCH,     1'b0};
      S_FINISH:    w = '{U_FINISH,    C_OUT_BUSY,  S_FINISH,    1'b1};
      default:     w = '{U_NOP,       C_NEVER,     S_FETCH,     1'b1};
    endcase
    return w;
  endfunction

endpackage

### rtl/rpn_stack_mem.sv
// Operand stack storage: one write port, one registered read port.
module rpn_stack_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [31:0]   wr_data_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [31:0]   rd_data_o
);

  logic [31:0] mem_q [DEPTH];
  logic [31:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_q;

endmodule

### rtl/rpn_stack_calculator.sv
// Top level of the RPN calculator: microcoded sequencer, shared arithmetic unit, output register.
// Postfix evaluator, one ASCII character per input item. Digits push 0..9, + - * / ^ pop two
// operands (top is the right one) and push the result, ! replaces the top by its factorial,
// anything else is ignored. Arithmetic is 32-bit wrapping, division truncates toward zero. On
// the character flagged by tlast one result item is sent (value, error) and the stack clears.
// Errors are sticky for the rest of the expression: 1 underflow (also an empty stack at the
// end), 2 overflow, 3 divide by zero; value is 0 then. Each item walks a short microprogram:
// a digit, an ignored character or an item rejected in decode ends after decode, + - * take
// the ALU step, / runs the divide loop (it stops at init on a zero divisor), ^ runs a multiply
// and square step per significant exponent bit (no loop for an exponent at or below zero), and
// a factorial of n from 2 to 33 loops on the multiplier; any other argument ends at init. The
// divide loop takes one quotient bit per cycle and power and factorial loop on the one shared
// 32x32 multiplier. A result waits in the output register while the next item is already
// taken; the end of a further expression waits for that register.
module rpn_stack_calculator #(
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] symbol
  input  logic        s_axis_tlast_i,   // last character of the expression
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o    // [31:0] value, [33:32] error, [39:34] zero
);

  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int UW  = rpn_pkg::UPC_W;

  // Sequencer
  logic [UW-1:0]   upc_q, upc_d;
  rpn_pkg::ucode_t cw;
  logic            jump;

  // Item and stack control
  logic [7:0]      sym_q;
  logic            last_q;
  rpn_pkg::kind_e  kind;
  logic            is_bin;
  logic [SPW-1:0]  sp_q, sp_d;
  rpn_pkg::err_e   err_q, err_d;

  // Datapath
  logic [31:0] a_q, b_q, acc_q, rem_q, tos_q;
  logic [5:0]  cnt_q;
  logic        neg_q;
  logic [31:0] mul_x, mul_y, mul_p;
  logic [32:0] div_trial, div_diff;

  // Stack port
  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [31:0]   wr_data, rd_data;

  // Output register
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_value_q;
  logic [1:0]  out_err_q;
  logic        out_busy, out_load, s_fire, m_fire, simple;

  assign cw     = rpn_pkg::ucode_rom(upc_q);
  assign kind   = rpn_pkg::classify(sym_q);
  assign is_bin = (kind == rpn_pkg::K_ADD) || (kind == rpn_pkg::K_SUB) ||
                  (kind == rpn_pkg::K_MUL) || (kind == rpn_pkg::K_DIV) ||
                  (kind == rpn_pkg::K_POW);

  assign s_axis_tready_o = (cw.uop == rpn_pkg::U_FETCH);
  assign s_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign m_fire   = out_valid_q && m_axis_tready_i;
  assign out_busy = last_q && out_valid_q && !m_axis_tready_i;
  assign out_load = (cw.uop == rpn_pkg::U_FINISH) && last_q && !out_busy;

  // Items that finish in decode: held error, push, ignored, or too few operands
  assign simple = (err_q != rpn_pkg::ERR_NONE) || (kind == rpn_pkg::K_DIGIT) ||
                  (kind == rpn_pkg::K_OTHER) ||
                  ((kind == rpn_pkg::K_FACT) && (sp_q == '0)) ||
                  (is_bin && (sp_q < SPW'(2)));

  // Conditional jump select
  always_comb begin
    jump = 1'b0;
    case (cw.cond)
      rpn_pkg::C_NEVER:     jump = 1'b0;
      rpn_pkg::C_ALWAYS:    jump = 1'b1;
      rpn_pkg::C_NO_ACC:    jump = !s_axis_tvalid_i;
      rpn_pkg::C_SIMPLE:    jump = simple;
      rpn_pkg::C_IS_FACT:   jump = (kind == rpn_pkg::K_FACT);
      rpn_pkg::C_IS_DIV:    jump = (kind == rpn_pkg::K_DIV);
      rpn_pkg::C_IS_POW:    jump = (kind == rpn_pkg::K_POW);
      rpn_pkg::C_DIVZ:      jump = (b_q == '0);
      rpn_pkg::C_CNT_NZ:    jump = (cnt_q != 6'd1);
      rpn_pkg::C_EXP_LE0:   jump = b_q[31] || (b_q == '0);
      rpn_pkg::C_E_NZ:      jump = (b_q[31:1] != '0);
      rpn_pkg::C_FACT_TRIV: jump = b_q[31] || (b_q < 32'd2) ||
                                   (b_q >= rpn_pkg::FACT_ZERO_FROM);
      rpn_pkg::C_I_LT_N:    jump = (cnt_q != b_q[5:0]);
      rpn_pkg::C_OUT_BUSY:  jump = out_busy;
      default:              jump = 1'b0;
    endcase
  end

  always_comb begin
    if (jump)        upc_d = cw.target;
    else if (cw.ret) upc_d = rpn_pkg::S_FETCH;
    else             upc_d = upc_q + UW'(1);
  end

  // Shared multiplier, low 32 bits of the product
  always_comb begin
    mul_x = a_q;
    mul_y = b_q;
    case (cw.uop)
      rpn_pkg::U_POW_MUL:   begin mul_x = acc_q; mul_y = a_q; end
      rpn_pkg::U_POW_SQ:    begin mul_x = a_q;   mul_y = a_q; end
      rpn_pkg::U_FACT_STEP: begin mul_x = acc_q; mul_y = {26'd0, cnt_q}; end
      default:              begin mul_x = a_q;   mul_y = b_q; end
    endcase
  end
  assign mul_p = mul_x * mul_y;

  // Restoring divide, one quotient bit per step; a_q shifts dividend out, quotient in
  assign div_trial = {rem_q, a_q[31]};
  assign div_diff  = div_trial - {1'b0, b_q};

  // Stack access
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = AW'(sp_q);
    wr_data = acc_q;
    rd_addr = AW'(sp_q - SPW'(1));
    sp_d    = sp_q;
    err_d   = err_q;
    case (cw.uop)
      rpn_pkg::U_DECODE: begin
        if (err_q == rpn_pkg::ERR_NONE) begin
          if (kind == rpn_pkg::K_DIGIT) begin
            if (sp_q >= SPW'(STACK_DEPTH)) begin
              err_d = rpn_pkg::ERR_OVER;
            end else begin
              wr_en   = 1'b1;
              wr_data = {28'd0, sym_q[3:0]};
              sp_d    = sp_q + SPW'(1);
            end
          end else if (simple && (kind != rpn_pkg::K_OTHER)) begin
            err_d = rpn_pkg::ERR_UNDER;
          end
        end
      end
      rpn_pkg::U_LD_B: rd_addr = AW'(sp_q - SPW'(2));
      rpn_pkg::U_DIV_INIT: begin
        if (b_q == '0) err_d = rpn_pkg::ERR_DIV0;
      end
      rpn_pkg::U_WB: begin
        wr_en = 1'b1;
        if (kind == rpn_pkg::K_FACT) begin
          wr_addr = AW'(sp_q - SPW'(1));
        end else begin
          wr_addr = AW'(sp_q - SPW'(2));
          sp_d    = sp_q - SPW'(1);
        end
      end
      rpn_pkg::U_FINISH: begin
        if (out_load) begin
          sp_d  = '0;
          err_d = rpn_pkg::ERR_NONE;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_d = (out_valid_q && !m_fire) || out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= rpn_pkg::S_FETCH;
      sp_q        <= '0;
      err_q       <= rpn_pkg::ERR_NONE;
      out_valid_q <= 1'b0;
    end else begin
      upc_q       <= upc_d;
      sp_q        <= sp_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      sym_q  <= s_axis_tdata_i;
      last_q <= s_axis_tlast_i;
    end
    if (out_load) begin
      if (err_q != rpn_pkg::ERR_NONE) begin
        out_value_q <= '0;
        out_err_q   <= err_q;
      end else if (sp_q == '0) begin
        out_value_q <= '0;
        out_err_q   <= rpn_pkg::ERR_UNDER;
      end else begin
        out_value_q <= tos_q;
        out_err_q   <= rpn_pkg::ERR_NONE;
      end
    end
    if ((cw.uop == rpn_pkg::U_DECODE) && wr_en) tos_q <= wr_data;
    case (cw.uop)
      rpn_pkg::U_LD_B: b_q <= rd_data;
      rpn_pkg::U_LD_A: a_q <= rd_data;
      rpn_pkg::U_ALU: begin
        if (kind == rpn_pkg::K_ADD)      acc_q <= a_q + b_q;
        else if (kind == rpn_pkg::K_SUB) acc_q <= a_q - b_q;
        else                             acc_q <= mul_p;
      end
      rpn_pkg::U_DIV_INIT: begin
        neg_q <= a_q[31] ^ b_q[31];
        a_q   <= a_q[31] ? (32'd0 - a_q) : a_q;
        b_q   <= b_q[31] ? (32'd0 - b_q) : b_q;
        rem_q <= '0;
        cnt_q <= rpn_pkg::DIV_STEPS;
      end
      rpn_pkg::U_DIV_STEP: begin
        cnt_q <= cnt_q - 6'd1;
        if (!div_diff[32]) begin
          rem_q <= div_diff[31:0];
          a_q   <= {a_q[30:0], 1'b1};
        end else begin
          rem_q <= div_trial[31:0];
          a_q   <= {a_q[30:0], 1'b0};
        end
      end
      rpn_pkg::U_DIV_FIX: acc_q <= neg_q ? (32'd0 - a_q) : a_q;
      rpn_pkg::U_POW_INIT: acc_q <= 32'd1;
      rpn_pkg::U_POW_MUL: begin
        if (b_q[0]) acc_q <= mul_p;
      end
      rpn_pkg::U_POW_SQ: begin
        a_q <= mul_p;
        b_q <= {1'b0, b_q[31:1]};
      end
      rpn_pkg::U_FACT_INIT: begin
        acc_q <= (!b_q[31] && (b_q >= rpn_pkg::FACT_ZERO_FROM)) ? 32'd0 : 32'd1;
        cnt_q <= 6'd2;
      end
      rpn_pkg::U_FACT_STEP: begin
        acc_q <= mul_p;
        cnt_q <= cnt_q + 6'd1;
      end
      rpn_pkg::U_WB: tos_q <= acc_q;
      default: ;
    endcase
  end

  rpn_stack_mem #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_stack (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0, out_err_q, out_value_q};

`ifndef SYNTHESIS
  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SPW'(STACK_DEPTH))
    else $error("stack pointer beyond depth");

  a_fetch_to_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> (upc_q == rpn_pkg::S_DECODE))
    else $error("accepted item not decoded next");

  a_err_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cw.uop == rpn_pkg::U_DECODE) && (err_q != rpn_pkg::ERR_NONE)) |-> !wr_en)
    else $error("stack written while error held");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == rpn_pkg::S_DIV_STEP) |-> (cnt_q != '0))
    else $error("divide step counter underran");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || m_axis_tready_i))
    else $error("result loaded over a pending one");

  a_clear_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> ((sp_q == '0) && (err_q == rpn_pkg::ERR_NONE) && out_valid_q))
    else $error("stack not cleared after result");
`endif

endmodule

### verif/rpn_checker.sv
// Scoreboard for the RPN calculator: evaluates each expression aside, checks every result item.
`timescale 1ns / 100ps
module rpn_checker #(
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  in_symbol_i,
  input  logic        in_last_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [39:0] out_data_i,    // [31:0] value, [33:32] error, [39:34] zero
  output int          fail_count_o,
  output int          pending_o,
  output int          results_o,
  output int          error_results_o
);

  typedef struct packed {
    logic [31:0]   value;
    rpn_pkg::err_e code;
  } rpn_result_t;

  logic [31:0]   opnd [STACK_DEPTH];
  int unsigned   depth = 0;
  rpn_pkg::err_e held_err = rpn_pkg::ERR_NONE;
  rpn_result_t   answer_q [$];

  function automatic logic [31:0] quot_trunc(input logic [31:0] lhs, input logic [31:0] rhs);
    logic [31:0] ml, mr, q;
    ml = lhs[31] ? -lhs : lhs;
    mr = rhs[31] ? -rhs : rhs;
    q  = ml / mr;
    return (lhs[31] ^ rhs[31]) ? -q : q;
  endfunction

  function automatic logic [31:0] fact_wrap(input logic [31:0] n);
    logic [31:0] acc;
    logic [31:0] k;
    acc = 32'd1;
    if (n[31]) return 32'd1;
    if (n >= 32'd34) return 32'd0;
    for (k = 32'd2; k <= n; k++) acc = acc * k;
    return acc;
  endfunction

  // square-and-multiply, everything wraps at 32 bits
  function automatic logic [31:0] pow_wrap(input logic [31:0] base, input logic [31:0] expo);
    logic [31:0] acc, b, e;
    acc = 32'd1;
    b   = base;
    e   = expo;
    if (e[31] || e == '0) return 32'd1;
    while (e != '0) begin
      if (e[0]) acc = acc * b;
      b = b * b;
      e = e >> 1;
    end
    return acc;
  endfunction

  task automatic eval_symbol(input logic [7:0] sym);
    logic [31:0] lhs, rhs, res;
    if (sym >= rpn_pkg::CH_0 && sym <= rpn_pkg::CH_9) begin
      if (depth >= STACK_DEPTH) held_err = rpn_pkg::ERR_OVER;
      else begin
        opnd[depth] = 32'(sym - rpn_pkg::CH_0);
        depth++;
      end
    end else if (sym == rpn_pkg::CH_BANG) begin
      if (depth < 1) held_err = rpn_pkg::ERR_UNDER;
      else opnd[depth-1] = fact_wrap(opnd[depth-1]);
    end else if (sym inside {rpn_pkg::CH_PLUS, rpn_pkg::CH_MINUS, rpn_pkg::CH_STAR,
                             rpn_pkg::CH_SLASH, rpn_pkg::CH_CARET}) begin
      if (depth < 2) held_err = rpn_pkg::ERR_UNDER;
      else begin
        rhs = opnd[depth-1];
        lhs = opnd[depth-2];
        if (sym == rpn_pkg::CH_SLASH && rhs == '0) held_err = rpn_pkg::ERR_DIV0;
        else begin
          case (sym)
            rpn_pkg::CH_PLUS:  res = lhs + rhs;
            rpn_pkg::CH_MINUS: res = lhs - rhs;
            rpn_pkg::CH_STAR:  res = lhs * rhs;
            rpn_pkg::CH_SLASH: res = quot_trunc(lhs, rhs);
            default:           res = pow_wrap(lhs, rhs);
          endcase
          depth--;
          opnd[depth-1] = res;
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rpn_result_t want, got;
    if (!rst_ni) begin
      depth    = 0;
      held_err = rpn_pkg::ERR_NONE;
      answer_q.delete();
      pending_o = 0;
    end else begin
      // results first: an item accepted on this edge cannot produce one yet
      if (out_valid_i && out_ready_i) begin
        got.value = out_data_i[31:0];
        got.code  = rpn_pkg::err_e'(out_data_i[33:32]);
        results_o++;
        if (got.code != rpn_pkg::ERR_NONE) error_results_o++;
        if (answer_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%0t: result with none expected: value %0d error %0d", $realtime,
                     $signed(got.value), got.code);
        end else begin
          want = answer_q.pop_front();
          if (want !== got || out_data_i[39:34] !== '0) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("%0t: expected value %0d error %0d, got value %0d error %0d pad %h",
                       $realtime, $signed(want.value), want.code, $signed(got.value), got.code,
                       out_data_i[39:34]);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (held_err == rpn_pkg::ERR_NONE) eval_symbol(in_symbol_i);
        if (in_last_i) begin
          want.value = '0;
          want.code  = held_err;
          if (held_err == rpn_pkg::ERR_NONE) begin
            if (depth == 0) want.code = rpn_pkg::ERR_UNDER;
            else want.value = opnd[depth-1];
          end
          answer_q.push_back(want);
          depth    = 0;
          held_err = rpn_pkg::ERR_NONE;
        end
      end
      pending_o = answer_q.size();
    end
  end

endmodule

### verif/tb_rpn_stack_calculator.sv
// Testbench top for the RPN calculator: clock, reset, stimulus, output backpressure, verdict.
`timescale 1ns / 100ps
module tb_rpn_stack_calculator;

  localparam int DEPTH        = 16;
  localparam int RAND_ITEMS   = 600;    // digit/operator items in the random part
  localparam int HOLD_CYCLES  = 400;    // long output stall, enough to back up the input
  localparam int DRAIN_CYCLES = 200;    // well past the slowest item

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = '0;          // [7:0] symbol
  logic        s_tlast  = 1'b0;        // last character of the expression
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;                // [31:0] value, [33:32] error, [39:34] zero

  int fails, pending, results, error_results;

  // phase flags, written by the sender only
  logic steady   = 1'b0;               // final stretch: no idling on either side
  logic hold_req = 1'b0;               // ask the receiver for its long stall
  logic hold_taken = 1'b0;             // written by the receiver only

  int         op_items    = 0;         // digits and operators sent (ignored chars excluded)
  int         expressions = 0;
  logic [7:0] expr_q [$];              // characters of the expression being built

  always #10 clk_i = ~clk_i;

  rpn_stack_calculator #(.STACK_DEPTH(DEPTH)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  rpn_checker #(.STACK_DEPTH(DEPTH)) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_tvalid),
    .in_ready_i      (s_tready),
    .in_symbol_i     (s_tdata),
    .in_last_i       (s_tlast),
    .out_valid_i     (m_tvalid),
    .out_ready_i     (m_tready),
    .out_data_i      (m_tdata),
    .fail_count_o    (fails),
    .pending_o       (pending),
    .results_o       (results),
    .error_results_o (error_results)
  );

  // --------------------------------------------------------------------------
  // Character helpers
  // --------------------------------------------------------------------------
  function automatic bit meaningful(input logic [7:0] c);
    return (c >= rpn_pkg::CH_0 && c <= rpn_pkg::CH_9) ||
           (c inside {rpn_pkg::CH_PLUS, rpn_pkg::CH_MINUS, rpn_pkg::CH_STAR,
                      rpn_pkg::CH_SLASH, rpn_pkg::CH_CARET, rpn_pkg::CH_BANG});
  endfunction

  function automatic logic [7:0] rand_digit();
    return rpn_pkg::CH_0 + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_binop();
    logic [7:0] op;
    case ($urandom_range(0, 4))
      0:       op = rpn_pkg::CH_PLUS;
      1:       op = rpn_pkg::CH_MINUS;
      2:       op = rpn_pkg::CH_STAR;
      3:       op = rpn_pkg::CH_SLASH;
      default: op = rpn_pkg::CH_CARET;
    endcase
    return op;
  endfunction

  // Any byte the block ignores. All meaningful codes sit below 0x80, so flipping
  // bit 7 turns a hit into an ignored character; this also exercises bit 7.
  function automatic logic [7:0] noise_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if (meaningful(c)) c ^= 8'h80;
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Sender. Entered and left at a falling edge; tvalid is left high after the
  // handshake so the next item can follow back to back without a glitch.
  // --------------------------------------------------------------------------
  task automatic send_char(input logic [7:0] sym, input logic last);
    int gap;
    if (!steady && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= sym;
    s_tlast  <= last;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    if (meaningful(sym)) op_items++;
    @(negedge clk_i);
  endtask

  task automatic send_expr();
    int i;
    for (i = 0; i < expr_q.size(); i++) send_char(expr_q[i], i == expr_q.size() - 1);
    expressions++;
  endtask

  task automatic load_text(input string txt);
    int i;
    expr_q.delete();
    for (i = 0; i < txt.len(); i++) expr_q.push_back(txt[i]);
  endtask

  // Well-formed postfix with random content: tracks stack depth so the stack
  // never runs dry, then folds down to one entry. Noisy variant sprinkles
  // ignored characters in between.
  task automatic build_wellformed(input bit noisy);
    int len, level, r;
    len   = $urandom_range(1, 14);
    level = 0;
    expr_q.delete();
    repeat (len) begin
      r = $urandom_range(0, 9);
      if (noisy && $urandom_range(0, 2) == 0) expr_q.push_back(noise_char());
      if (level >= 2 && (r < 4 || level >= DEPTH - 1)) begin
        expr_q.push_back(rand_binop());
        level--;
      end else if (level >= 1 && r == 4) begin
        expr_q.push_back(rpn_pkg::CH_BANG);
      end else begin
        expr_q.push_back(rand_digit());
        level++;
      end
    end
    while (level > 1) begin
      expr_q.push_back(rand_binop());
      level--;
    end
    if (noisy && $urandom_range(0, 1) == 0) expr_q.push_back(noise_char());
  endtask

  // Push around the stack limit: one short of full, full, and overflow from one or two more digits
  task automatic build_flood();
    int n, k;
    n = $urandom_range(DEPTH - 1, DEPTH + 2);
    k = $urandom_range(0, 3);
    expr_q.delete();
    repeat (n) expr_q.push_back(rand_digit());
    repeat (k) expr_q.push_back(rand_binop());
  endtask

  // Short random junk: mostly underflow, some divide by zero, raw bytes
  task automatic build_broken();
    int len;
    len = $urandom_range(1, 6);
    expr_q.delete();
    repeat (len) begin
      case ($urandom_range(0, 3))
        0:       expr_q.push_back(rand_digit());
        1:       expr_q.push_back(rand_binop());
        2:       expr_q.push_back(rpn_pkg::CH_BANG);
        default: expr_q.push_back(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stall bursts, one long hold-off on request, none at the end
  // --------------------------------------------------------------------------
  initial begin
    int gap;
    forever begin
      @(negedge clk_i);
      if (!rst_ni) begin
        m_tready <= 1'b0;
      end else if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else if (!steady && $urandom_range(0, 4) == 0) begin
        gap = $urandom_range(1, 5);
        m_tready <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int  rand_start, done;
    bit  paused;
    paused = 1'b0;

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part.
    // 2^31 wraps to the most negative value, then divided by minus one
    load_text("2999++4+^01-/");
    send_expr();
    // factorial on an empty stack: underflow
    expr_q = '{rpn_pkg::CH_BANG};
    send_expr();
    // only ignored characters: empty stack at the end, both byte extremes
    expr_q = '{8'h00, 8'hFF};
    send_expr();
    // factorial of 36 wraps to zero
    load_text("94*!");
    send_expr();
    // divide by zero, then the trailing digit must be ignored
    load_text("50/3");
    send_expr();
    // zero exponent gives one, factorial of one gives one
    load_text("10^!");
    send_expr();

    // Random part. Milestones: long output stall, a full drain, then a
    // stretch without any idling on either side.
    rand_start = op_items;
    done       = 0;
    while (done < RAND_ITEMS) begin
      if (done >= 150) hold_req = 1'b1;
      if (done >= 350 && !paused) begin
        paused = 1'b1;
        s_tvalid <= 1'b0;
        wait (pending == 0);
        @(negedge clk_i);
      end
      if (done >= 480) steady = 1'b1;
      case ($urandom_range(0, 99)) inside
        [0:64]:  build_wellformed(1'b0);
        [65:77]: build_wellformed(1'b1);
        [78:84]: build_flood();
        default: build_broken();
      endcase
      send_expr();
      done = op_items - rand_start;
    end
    s_tvalid <= 1'b0;

    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d expressions with %0d digit/operator items; %0d results checked,",
             expressions, op_items, results);
    $display("%0d of them with an error code; one long output stall and one full drain.",
             error_results);
    if (fails == 0) begin
      $display("rpn_stack_calculator test passed");
    end else begin
      $display("rpn_stack_calculator test failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("rpn_stack_calculator test failed");
    $finish;
  end

endmodule

### rpn_stack_calculator.f
rtl/rpn_pkg.sv
rtl/rpn_stack_mem.sv
rtl/rpn_stack_calculator.sv
verif/rpn_checker.sv
verif/tb_rpn_stack_calculator.sv
